[rtl/fld_pkg.sv]
// Shared types, constants and the coefficient table of the lowpass decimator.
`timescale 1ns / 1ps
package fld_pkg;

  // Channel and register field widths.
  localparam int SAMPLE_W = 16;
  localparam int BS_W     = 13;
  localparam int BL_W     = 20;
  localparam int IDX_W    = 20;
  localparam int POS_W    = 12;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 1;

  // Default filter geometry.
  localparam int TAPS_DEF  = 49;
  localparam int DECIM_DEF = 4;

  // Register indexes on the write port.
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'd1;

  // Register reset values and block size limit.
  localparam logic [BS_W-1:0] BLOCK_SIZE_RST    = 13'd1024;
  localparam logic [BL_W-1:0] BUFFER_LENGTH_RST = 20'd720000;
  localparam logic [BS_W-1:0] MAX_BLOCK         = 13'd4096;

  // Datapath of the digit-serial multiply-accumulate.
  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 7;
  localparam int ROM_LEN    = 49;
  localparam int DIGIT_W    = 4;
  localparam int DIGITS     = SAMPLE_W / DIGIT_W;
  localparam int DCNT_W     = $clog2(DIGITS);
  localparam int SH_W       = $clog2(SAMPLE_W);
  localparam int PROD_W     = COEF_W + DIGIT_W + 1;
  localparam int ACC_W      = 34;
  localparam int FRAC_W     = 15;
  localparam int Y_W        = ACC_W - FRAC_W;

  // Rounding offsets for half away from zero in Q.15.
  localparam logic signed [ACC_W-1:0] RND_POS = 34'sd16384;
  localparam logic signed [ACC_W-1:0] RND_NEG = 34'sd16383;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FINISH
  } st_t;

  // Q1.15 lowpass coefficients.
  localparam coef_t COEF_ROM [ROM_LEN] = '{
       16'sd28,   16'sd329,   16'sd333,   16'sd372,   16'sd285,    16'sd86,
     -16'sd170,  -16'sd384,  -16'sd451,  -16'sd309,    16'sd18,   16'sd414,
      16'sd704,   16'sd719,   16'sd379,  -16'sd251,  -16'sd949, -16'sd1397,
    -16'sd1285,  -16'sd431,  16'sd1125,  16'sd3104,  16'sd5054,  16'sd6480,
     16'sd7003,  16'sd6480,  16'sd5054,  16'sd3104,  16'sd1125,  -16'sd431,
    -16'sd1285, -16'sd1397,  -16'sd949,  -16'sd251,   16'sd379,   16'sd719,
      16'sd704,   16'sd414,    16'sd18,  -16'sd309,  -16'sd451,  -16'sd384,
     -16'sd170,    16'sd86,   16'sd285,   16'sd372,   16'sd333,   16'sd329,
       16'sd28
  };

  // Coefficient of a tap; taps past the table weigh zero.
  function automatic coef_t coef_at(input logic [COEF_IDX_W-1:0] idx);
    coef_t c;
    c = '0;
    if (idx < COEF_IDX_W'(ROM_LEN)) begin
      c = COEF_ROM[idx[5:0]];
    end
    return c;
  endfunction

endpackage

[rtl/fld_if.sv]
// Valid/ready channel interfaces for input samples and filtered results.
`timescale 1ns / 1ps
interface fld_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fld_pkg::SAMPLE_W-1:0]  sample;
  logic                                 restart;

  modport source(output valid, sample, restart, input ready);
  modport sink(input valid, sample, restart, output ready);
endinterface

interface fld_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [fld_pkg::SAMPLE_W-1:0]  filtered;
  logic        [fld_pkg::IDX_W-1:0]     out_index;
  logic                                 block_done;

  modport source(output valid, filtered, out_index, block_done, input ready);
  modport sink(input valid, filtered, out_index, block_done, output ready);
endinterface

[rtl/fir_lowpass_decimator.sv]
// Lowpass FIR decimator top level with a digit-serial multiply-accumulate.
`timescale 1ns / 1ps
// Takes one signed 16-bit sample per input beat and emits one rounded, saturated
// lowpass result with its store index after every DECIMATION-th sample of an
// enabled block. A sample that does not close a decimation period is taken
// without a filter run. A sample that closes one in an enabled block starts a
// run that holds off the input: a single 16 x 5 bit multiplier walks the taps one
// after another and eats each stored sample four bits per cycle while the delay
// line rotates past it. A finished result waits in an output register, so the
// next sample is taken while it is still pending. The user must write registers
// through wr_en, wr_index and wr_data only while the block is idle; the block
// itself does not enforce this.
module fir_lowpass_decimator #(
  parameter int TAPS       = fld_pkg::TAPS_DEF,
  parameter int DECIMATION = fld_pkg::DECIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  fld_in_if.sink                           din,
  fld_out_if.source                        dout,
  input  logic                             wr_en,
  input  logic [fld_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [fld_pkg::CFG_W-1:0]        wr_data
);
  import fld_pkg::*;

  localparam int TAP_W = $clog2(TAPS);
  localparam int PH_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  // Configuration and sequencing state.
  logic [BS_W-1:0]   block_size;
  logic [BL_W-1:0]   buffer_length;
  logic [PH_W-1:0]   phase;
  logic [POS_W-1:0]  block_position;
  logic [IDX_W-1:0]  write_index;
  logic              block_enabled;
  sample_t           line [TAPS];

  // Multiply-accumulate state.
  st_t                      state, state_next;
  logic [TAP_W-1:0]         tap;
  logic [DCNT_W-1:0]        dcnt;
  logic [SAMPLE_W-1:0]      samp_sr;
  logic signed [ACC_W-1:0]  acc;
  logic [IDX_W-1:0]         res_index;
  logic                     res_last;

  // Output register.
  logic                     out_valid;
  sample_t                  out_filtered;
  logic [IDX_W-1:0]         out_idx;
  logic                     out_last;

  logic accept, load_out, tap_done, mac_done;

  // Effective block size and the view of the counters after a restart.
  logic [BS_W-1:0]   bs_eff;
  logic [IDX_W-1:0]  wi_eff;
  logic [POS_W-1:0]  pos_eff;
  logic [PH_W-1:0]   ph_eff;
  logic              en_eff, dec_end, last, fire;

  always_comb begin
    if (block_size == '0) begin
      bs_eff = BS_W'(1);
    end else if (block_size > MAX_BLOCK) begin
      bs_eff = MAX_BLOCK;
    end else begin
      bs_eff = block_size;
    end
    wi_eff  = din.restart ? '0 : write_index;
    pos_eff = din.restart ? '0 : block_position;
    ph_eff  = din.restart ? '0 : phase;
    if (ph_eff == '0 && pos_eff == '0) begin
      en_eff = ({1'b0, wi_eff} + (IDX_W + 1)'(bs_eff)) < {1'b0, buffer_length};
    end else begin
      en_eff = block_enabled;
    end
    dec_end = ((PH_W + 1)'(ph_eff) + (PH_W + 1)'(1)) >= (PH_W + 1)'(DECIMATION);
    last    = (BS_W'(pos_eff) + BS_W'(1)) >= bs_eff;
    fire    = accept && dec_end && en_eff;
  end

  // One digit of the current tap's sample times its coefficient.
  logic signed [DIGIT_W:0]   digit;
  coef_t                     coef;
  logic signed [PROD_W-1:0]  prod;
  logic [SH_W-1:0]           shamt;
  logic signed [ACC_W-1:0]   partial;

  always_comb begin
    digit    = {(dcnt == DCNT_W'(DIGITS - 1)) & samp_sr[DIGIT_W-1], samp_sr[DIGIT_W-1:0]};
    coef     = coef_at(COEF_IDX_W'(tap));
    prod     = PROD_W'(coef * digit);
    shamt    = SH_W'(dcnt) * SH_W'(DIGIT_W);
    partial  = ACC_W'(prod) <<< shamt;
    tap_done = (dcnt == DCNT_W'(DIGITS - 1));
    mac_done = tap_done && (tap == TAP_W'(TAPS - 1));
  end

  // Rounding half away from zero and saturation of the finished sum.
  logic signed [ACC_W-1:0] rnd;
  logic signed [Y_W-1:0]   y;
  sample_t                 y_sat;

  always_comb begin
    rnd = acc + (acc[ACC_W-1] ? RND_NEG : RND_POS);
    y   = Y_W'(rnd >>> FRAC_W);
    if (y > Y_W'(32767)) begin
      y_sat = 16'sh7FFF;
    end else if (y < -Y_W'(32768)) begin
      y_sat = 16'sh8000;
    end else begin
      y_sat = SAMPLE_W'(y);
    end
  end

  // Next state and handshake controls.
  always_comb begin
    state_next = state;
    din.ready  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        din.ready = 1'b1;
        if (fire) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || dout.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign accept = din.valid && din.ready;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size    <= BLOCK_SIZE_RST;
      buffer_length <= BUFFER_LENGTH_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_BLOCK_SIZE:    block_size    <= wr_data[BS_W-1:0];
        REG_BUFFER_LENGTH: buffer_length <= wr_data[BL_W-1:0];
        default: ;
      endcase
    end
  end

  // Block and decimation counters, updated once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= '0;
      block_position <= '0;
      write_index    <= '0;
      block_enabled  <= 1'b1;
    end else if (accept) begin
      block_enabled <= en_eff;
      write_index   <= fire ? wi_eff + IDX_W'(1) : wi_eff;
      if (dec_end) begin
        phase          <= '0;
        block_position <= last ? '0 : pos_eff + POS_W'(1);
      end else begin
        phase          <= ph_eff + PH_W'(1);
        block_position <= pos_eff;
      end
    end
  end

  // Delay line: shifts on an enabled beat, rotates by one tap during the MAC.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        line[i] <= '0;
      end
    end else if (accept && en_eff) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line[i] <= line[i + 1];
      end
      line[TAPS-1] <= din.sample;
    end else if (state == ST_MAC && tap_done) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line[i] <= line[i + 1];
      end
      line[TAPS-1] <= line[0];
    end
  end

  // Digit-serial multiply-accumulate over the taps.
  always_ff @(posedge clk) begin
    if (rst) begin
      tap  <= '0;
      dcnt <= '0;
    end else if (fire) begin
      tap  <= '0;
      dcnt <= '0;
    end else if (state == ST_MAC) begin
      if (tap_done) begin
        dcnt <= '0;
        tap  <= mac_done ? '0 : tap + TAP_W'(1);
      end else begin
        dcnt <= dcnt + DCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc       <= '0;
      samp_sr   <= line[1];
      res_index <= wi_eff;
      res_last  <= last;
    end else if (state == ST_MAC) begin
      acc <= acc + partial;
      if (tap_done) begin
        samp_sr <= line[1];
      end else begin
        samp_sr <= samp_sr >> DIGIT_W;
      end
    end
  end

  // Output register holds a result until its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_filtered <= y_sat;
      out_idx      <= res_index;
      out_last     <= res_last;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.filtered   = out_filtered;
  assign dout.out_index  = out_idx;
  assign dout.block_done = out_last;

endmodule

[rtl/fld_checker.sv]
// Port-level checks of the lowpass decimator and their binding to the top level.
`timescale 1ns / 1ps
module fld_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [fld_pkg::SAMPLE_W-1:0] filtered,
  input logic [fld_pkg::IDX_W-1:0]        out_index,
  input logic                             block_done
);

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered) && $stable(out_index)
      && $stable(block_done))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending right after reset");

  // A new result only appears after the input side was held off for the filter run.
  a_result_after_run: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a filter run");

  // The input side is not released again at once when a filter run starts.
  a_run_length: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |=> !in_ready)
    else $error("filter run ended too early");

  // A filter run only starts on an accepted input beat.
  a_run_after_beat: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input held off without an accepted beat");

endmodule

bind fir_lowpass_decimator fld_checker u_fld_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .filtered   (dout.filtered),
  .out_index  (dout.out_index),
  .block_done (dout.block_done)
);

[sim/fir_lowpass_decimator_test.sv]
// Self-checking testbench for the lowpass FIR decimator with a scoreboard class.
`timescale 1ns / 1ps
module fir_lowpass_decimator_test;
  import fld_pkg::*;

  localparam int N_TAPS        = 49;
  localparam int DECIM         = 4;
  localparam int BLOCK_CAP     = 4096;
  localparam int BS_RESET      = 1024;
  localparam int BL_RESET      = 720000;
  localparam int MAX_GAP       = 14;
  localparam int SETTLE_CYCLES = 250;
  localparam int LONG_HOLD     = 3000;
  localparam int HOLD_AT       = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SAT_HI        = 32767;
  localparam int SAT_LO        = -32768;

  // Two taps whose products sum to exactly half an output step: 28 * 4 + 18 * 904 = 16384.
  localparam int TIE_TAP_A   = 0;
  localparam int TIE_TAP_B   = 10;
  localparam int TIE_VALUE_A = 4;
  localparam int TIE_VALUE_B = 904;

  // Q1.15 lowpass coefficients, oldest tap first.
  localparam int LP_COEF [N_TAPS] = '{
       28,   329,   333,   372,   285,    86,  -170,  -384,
     -451,  -309,    18,   414,   704,   719,   379,  -251,
     -949, -1397, -1285,  -431,  1125,  3104,  5054,  6480,
     7003,  6480,  5054,  3104,  1125,  -431, -1285, -1397,
     -949,  -251,   379,   719,   704,   414,    18,  -309,
     -451,  -384,  -170,    86,   285,   372,   333,   329,
       28
  };

  // Opening samples at the reset setting: extremes, bit patterns and restarts.
  localparam int DIRECTED_SAMPLES [20] = '{
    0, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, 1,
    -1, 21845, -21846, 0, 32767, -32768, 255, -256, 4660, -4661
  };
  localparam bit DIRECTED_RESTART [20] = '{
    1, 0, 0, 0, 0, 0, 0, 0, 1, 0,
    0, 0, 0, 1, 0, 0, 0, 0, 1, 0
  };

  // Register settings walked after the opening part; the rate is one restart in that many.
  localparam int N_PLAN = 10;
  localparam int PLAN_BLOCK  [N_PLAN] = '{4, 1, 0, 20'hFFFFF, 3, 4096, 2, 6, 4097, 1};
  localparam int PLAN_BUFFER [N_PLAN] = '{720000, 30, 1, 1048575, 1048575, 4097, 3, 50,
                                          1048575, 1048575};
  localparam int PLAN_BEATS  [N_PLAN] = '{200, 100, 40, 80, 60, 40, 80, 100, 40, 100};
  localparam int PLAN_RATE   [N_PLAN] = '{60, 25, 10, 1000, 1000, 10, 15, 40, 1000, 100};
  localparam int N_RANDOM_SETTINGS = 4;

  typedef enum int {
    SEQ_NOISE,
    SEQ_FULL_SCALE,
    SEQ_HALF_TIE,
    SEQ_DC,
    SEQ_SMALL,
    SEQ_ALTERNATE
  } seq_kind_t;

  typedef struct {
    sample_t            filtered;
    logic [IDX_W-1:0]   out_index;
    logic               block_done;
  } decim_out_t;

  // Tracks the filter state, predicts each decimated output and checks the output beats.
  class decim_scoreboard;
    sample_t            hist [N_TAPS];
    logic [1:0]         phase;
    logic [POS_W-1:0]   block_pos;
    logic [IDX_W-1:0]   write_idx;
    logic               block_on;
    logic [BS_W-1:0]    block_size;
    logic [BL_W-1:0]    buffer_len;
    decim_out_t         pending_outputs [$];
    int                 errors;
    int                 samples_in;
    int                 outputs_checked;
    int                 block_ends;
    int                 saturated;

    function new();
      foreach (hist[i]) hist[i] = '0;
      phase           = '0;
      block_pos       = '0;
      write_idx       = '0;
      block_on        = 1'b1;
      block_size      = BS_W'(BS_RESET);
      buffer_len      = BL_W'(BL_RESET);
      errors          = 0;
      samples_in      = 0;
      outputs_checked = 0;
      block_ends      = 0;
      saturated       = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_BLOCK_SIZE: begin
          block_size = value[BS_W-1:0];
        end
        REG_BUFFER_LENGTH: begin
          buffer_len = value[BL_W-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    // Block size as used: zero counts as one, anything past the cap as the cap.
    function int block_len();
      if (block_size == '0) return 1;
      if (int'(block_size) > BLOCK_CAP) return BLOCK_CAP;
      return int'(block_size);
    endfunction

    // Dot product over the delay line, rounded half away from zero and saturated.
    function sample_t filter_window();
      longint acc;
      longint y;
      acc = 0;
      foreach (hist[i]) acc += longint'(LP_COEF[i]) * longint'(hist[i]);
      if (acc >= 0) y = (acc + 16384) / 32768;
      else y = -((-acc + 16384) / 32768);
      if (y > SAT_HI) y = SAT_HI;
      if (y < SAT_LO) y = SAT_LO;
      return sample_t'(y);
    endfunction

    function void add_sample(sample_t s, logic rs);
      int         bs;
      logic       last;
      decim_out_t r;
      bs = block_len();
      samples_in++;
      if (rs) begin
        write_idx = '0;
        block_pos = '0;
        phase     = '0;
      end
      // The store check is made once, on the first sample of a block.
      if (phase == '0 && block_pos == '0) begin
        block_on = (int'(write_idx) + bs) < int'(buffer_len);
      end
      if (block_on) begin
        for (int i = 0; i < N_TAPS - 1; i++) hist[i] = hist[i + 1];
        hist[N_TAPS - 1] = s;
      end
      if (int'(phase) == DECIM - 1) begin
        last = (int'(block_pos) + 1) >= bs;
        if (block_on) begin
          r.filtered   = filter_window();
          r.out_index  = write_idx;
          r.block_done = last;
          pending_outputs.push_back(r);
          write_idx = write_idx + IDX_W'(1);
          if (last) block_ends++;
          if (int'(r.filtered) == SAT_HI || int'(r.filtered) == SAT_LO) saturated++;
        end
        phase     = '0;
        block_pos = last ? '0 : block_pos + POS_W'(1);
      end else begin
        phase = phase + 2'd1;
      end
    endfunction

    function void check_output(decim_out_t got);
      decim_out_t want;
      if (pending_outputs.size() == 0) begin
        errors++;
        $display("%0t: output beat with none expected: filtered %0d index %0d block end %0b",
                 $time, got.filtered, got.out_index, got.block_done);
        return;
      end
      want = pending_outputs.pop_front();
      outputs_checked++;
      if (got.filtered !== want.filtered) begin
        errors++;
        $display("%0t: filtered mismatch: expected %0d, actual %0d",
                 $time, want.filtered, got.filtered);
      end
      if (got.out_index !== want.out_index) begin
        errors++;
        $display("%0t: out_index mismatch: expected %0d, actual %0d",
                 $time, want.out_index, got.out_index);
      end
      if (got.block_done !== want.block_done) begin
        errors++;
        $display("%0t: block_done mismatch: expected %0b, actual %0b",
                 $time, want.block_done, got.block_done);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [CFG_W-1:0]     wr_data;

  fld_in_if  din_ch ();
  fld_out_if dout_ch ();

  decim_scoreboard sb;
  logic            tx_rush = 1'b0;
  logic            rx_rush = 1'b0;
  int              beats_sent = 0;
  int              n_settings = 1;
  int              cycle_count = 0;

  fir_lowpass_decimator dut (
    .clk      (clk),
    .rst      (rst),
    .din      (din_ch),
    .dout     (dout_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // 12 ns clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fir_lowpass_decimator_test failed");
      $finish;
    end
  end

  // Offers one sample after a random idle gap and returns once the beat is taken.
  task automatic send_sample(input sample_t s, input logic rs);
    int gap;
    gap = tx_rush ? 0 : $urandom_range(0, MAX_GAP);
    if ($urandom_range(0, 39) == 0) tx_rush = !tx_rush;
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid   <= 1'b1;
    din_ch.sample  <= s;
    din_ch.restart <= rs;
    do begin
      @(posedge clk);
    end while (!din_ch.ready);
    sb.add_sample(s, rs);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic apply_setting(input int bs, input int bl);
    write_reg(REG_BLOCK_SIZE, CFG_W'(bs));
    write_reg(REG_BUFFER_LENGTH, CFG_W'(bl));
    wr_en <= 1'b0;
    n_settings++;
  endtask

  // Stops offering samples, waits for every expected output, then lets the block go quiet.
  task automatic drain_and_settle();
    din_ch.valid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random sequences: half noise, plus full windows that hit saturation and rounding ties.
  task automatic run_random(input int n, input int rate);
    int        first;
    int        len;
    int        pick;
    int        v;
    int        scale;
    bit        neg;
    seq_kind_t kind;
    first = beats_sent;
    while (beats_sent - first < n) begin
      pick = $urandom_range(0, 9);
      kind = seq_kind_t'((pick < 5) ? 0 : pick - 4);
      neg  = 1'($urandom_range(0, 1));
      case (kind)
        SEQ_FULL_SCALE, SEQ_HALF_TIE: begin
          // The window must end on an output sample, so it starts when the phase is last.
          while (int'(sb.phase) != DECIM - 1) send_sample(sample_t'($urandom), 1'b0);
          scale = 2 * $urandom_range(0, 17) + 1;
          for (int k = 0; k < N_TAPS; k++) begin
            if (kind == SEQ_FULL_SCALE) begin
              v = ((LP_COEF[k] > 0) != neg) ? SAT_HI : SAT_LO;
            end else begin
              v = (k == TIE_TAP_A) ? TIE_VALUE_A * scale :
                  (k == TIE_TAP_B) ? TIE_VALUE_B * scale : 0;
              if (neg) v = -v;
            end
            send_sample(sample_t'(v), 1'b0);
          end
        end
        SEQ_DC: begin
          len = $urandom_range(8, 24);
          v = ($urandom_range(0, 2) == 0) ? int'(sample_t'($urandom)) : (neg ? SAT_LO : SAT_HI);
          repeat (len) send_sample(sample_t'(v), 1'b0);
        end
        SEQ_SMALL: begin
          len = $urandom_range(4, 16);
          repeat (len) send_sample(sample_t'($urandom_range(0, 8) - 4), 1'b0);
        end
        SEQ_ALTERNATE: begin
          len = $urandom_range(8, 24);
          for (int k = 0; k < len; k++) begin
            send_sample(sample_t'(((k % 2 == 0) != neg) ? SAT_HI : SAT_LO), 1'b0);
          end
        end
        default: begin
          len = $urandom_range(1, 16);
          repeat (len) begin
            send_sample(sample_t'($urandom), $urandom_range(0, rate - 1) == 0);
          end
        end
      endcase
    end
  endtask

  // Output side: random back-pressure, one long hold-off so the block fills and stalls.
  initial begin
    int         wait_cycles;
    int         beats_taken;
    decim_out_t got;
    beats_taken = 0;
    dout_ch.ready <= 1'b0;
    do begin
      @(posedge clk);
    end while (rst !== 1'b0);
    forever begin
      wait_cycles = rx_rush ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) rx_rush = !rx_rush;
      if (beats_taken == HOLD_AT) wait_cycles += LONG_HOLD;
      if (wait_cycles > 0) begin
        dout_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!dout_ch.valid);
      got.filtered   = dout_ch.filtered;
      got.out_index  = dout_ch.out_index;
      got.block_done = dout_ch.block_done;
      sb.check_output(got);
      beats_taken++;
    end
  end

  // Main sequence: reset, opening samples, then one phase per register setting.
  initial begin
    sb = new();
    rst            <= 1'b1;
    din_ch.valid   <= 1'b0;
    din_ch.sample  <= '0;
    din_ch.restart <= 1'b0;
    wr_en          <= 1'b0;
    wr_index       <= '0;
    wr_data        <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_SAMPLES[i]) begin
      send_sample(sample_t'(DIRECTED_SAMPLES[i]), DIRECTED_RESTART[i]);
    end
    run_random(100, 50);
    drain_and_settle();

    for (int p = 0; p < N_PLAN; p++) begin
      apply_setting(PLAN_BLOCK[p], PLAN_BUFFER[p]);
      run_random(PLAN_BEATS[p], PLAN_RATE[p]);
      drain_and_settle();
    end

    // A few short blocks against small stores, so dropped blocks and restarts mix.
    repeat (N_RANDOM_SETTINGS) begin
      apply_setting($urandom_range(1, 10), $urandom_range(1, 80));
      run_random(60, 20);
      drain_and_settle();
    end

    $display("Run covered %0d input beats and %0d checked outputs over %0d register settings.",
             sb.samples_in, sb.outputs_checked, n_settings);
    $display("Outputs closing a block: %0d; outputs at a saturation limit: %0d; mismatches: %0d.",
             sb.block_ends, sb.saturated, sb.errors);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("fir_lowpass_decimator_test passed");
    end else begin
      $display("fir_lowpass_decimator_test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fld_pkg.sv
rtl/fld_if.sv
rtl/fir_lowpass_decimator.sv
rtl/fld_checker.sv
sim/fir_lowpass_decimator_test.sv
